// ===== rtl/core/gsdc_pkg.sv =====
// Shared types, constants and state encodings for the gas sensor compensator.
package gsdc_pkg;

  localparam int WIN_LOG2   = 3;
  localparam int WINDOW_LEN = 1 << WIN_LOG2;
  localparam int WIN_CENTER = WINDOW_LEN / 2;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 48;
  localparam int SUM_W    = SAMPLE_W + WIN_LOG2;

  localparam int SLOPE_W  = 24;
  localparam int OFFS_W   = 32;
  localparam int DEC_W    = 8;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  localparam int TAU_W    = 41;
  localparam int TC_W     = 40;
  localparam int EST_W    = 18;
  localparam int ESTX_W   = 21;

  localparam int MUL_STEPS = SAMPLE_W;
  localparam int QUO_W     = 19;
  localparam int NUM_W     = SAMPLE_W + TAU_W + 1;
  localparam int MCAND_W   = NUM_W - 1;
  localparam int DEN_W     = TIME_W + 8;
  localparam int REM_W     = DEN_W + 1;
  localparam int CNT_W     = 5;

  localparam logic [IDX_W-1:0] REG_RISE_SLOPE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RISE_OFFSET  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DECAY_SLOPE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DECAY_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_DECIMATION   = 3'd4;

  localparam logic signed [EST_W-1:0] EST_MAX = 18'sh1FFFF;
  localparam logic signed [EST_W-1:0] EST_MIN = 18'sh20000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]   stamp;
  } win_entry_t;

  typedef struct packed {
    logic fill;
    logic shift;
  } win_ctrl_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] mag;
    logic [TAU_W-1:0]    tau_q8;
    logic [TIME_W-1:0]   dt;
  } corr_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } corr_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_TAU,
    S_CORR,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_ADD,
    C_PRE,
    C_DIV,
    C_DONE
  } corr_state_t;

endpackage

// ===== rtl/core/gas_sensor_dynamics_compensator.sv =====
// Top level: config registers, decimation, inverse lag model and output register.
// A sample dropped by decimation enters the window but starts no estimate; an estimate
//   with no correction (first run or non-increasing time) passes S_LOAD, S_TAU, S_FINISH.
// Otherwise the serial multiply and divide run in S_CORR between S_TAU and S_FINISH;
//   one sample is in work at a time.
// Synchronous reset clears control and model state; the window refills from
//   the first sample after reset. No clearing pass is needed.
module gas_sensor_dynamics_compensator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gsdc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [gsdc_pkg::DATA_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gsdc_pkg::SAMPLE_W-1:0]     sample,
  input  logic [gsdc_pkg::TIME_W-1:0]       sample_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gsdc_pkg::EST_W-1:0] estimate,
  output logic [gsdc_pkg::TC_W-1:0]         time_constant,
  output logic [gsdc_pkg::TIME_W-1:0]       estimate_time
);

  logic [gsdc_pkg::SLOPE_W-1:0] rise_slope;
  logic [gsdc_pkg::OFFS_W-1:0]  rise_offset;
  logic [gsdc_pkg::SLOPE_W-1:0] decay_slope;
  logic [gsdc_pkg::OFFS_W-1:0]  decay_offset;
  logic [gsdc_pkg::DEC_W-1:0]   decimation;
  logic [gsdc_pkg::DEC_W-1:0]   dec_count;

  gsdc_pkg::ctrl_state_t state;
  gsdc_pkg::ctrl_state_t state_next;

  logic                           accept;
  logic                           dec_hit;
  logic                           load_out;
  logic [gsdc_pkg::SAMPLE_W-1:0]  win_avg;
  logic [gsdc_pkg::TIME_W-1:0]    win_time;

  logic [gsdc_pkg::SAMPLE_W-1:0]  baseline;
  logic [gsdc_pkg::SAMPLE_W-1:0]  prev_value;
  logic [gsdc_pkg::TIME_W-1:0]    prev_time;
  logic                           started;
  logic [gsdc_pkg::SAMPLE_W-1:0]  base_next;

  logic [gsdc_pkg::SAMPLE_W-1:0]  avg_r;
  logic [gsdc_pkg::TIME_W-1:0]    time_r;
  logic [gsdc_pkg::SAMPLE_W-1:0]  diff_r;
  logic [gsdc_pkg::SAMPLE_W-1:0]  mag_r;
  logic [gsdc_pkg::TIME_W-1:0]    dt_r;
  logic                           falling_r;
  logic                           first_r;
  logic                           skip_r;
  logic [gsdc_pkg::TAU_W-1:0]     tau_r;
  logic [gsdc_pkg::TAU_W-1:0]     tau_next;
  logic [gsdc_pkg::TAU_W:0]       tau_round;

  logic signed [gsdc_pkg::ESTX_W-1:0] est_wide;
  logic signed [gsdc_pkg::EST_W-1:0]  est_sat;

  gsdc_pkg::corr_req_t corr_req;
  gsdc_pkg::corr_rsp_t corr_rsp;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign dec_hit   = (dec_count == decimation);

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_slope   <= '0;
      rise_offset  <= '0;
      decay_slope  <= '0;
      decay_offset <= '0;
      decimation   <= gsdc_pkg::DEC_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        gsdc_pkg::REG_RISE_SLOPE:   rise_slope   <= cfg_data[gsdc_pkg::SLOPE_W-1:0];
        gsdc_pkg::REG_RISE_OFFSET:  rise_offset  <= cfg_data;
        gsdc_pkg::REG_DECAY_SLOPE:  decay_slope  <= cfg_data[gsdc_pkg::SLOPE_W-1:0];
        gsdc_pkg::REG_DECAY_OFFSET: decay_offset <= cfg_data;
        gsdc_pkg::REG_DECIMATION:   decimation   <= cfg_data[gsdc_pkg::DEC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gsdc_window u_window (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .sample      (sample),
    .sample_time (sample_time),
    .avg         (win_avg),
    .centre_time (win_time)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gsdc_pkg::S_IDLE: begin
        if (in_valid && dec_hit) state_next = gsdc_pkg::S_LOAD;
      end
      gsdc_pkg::S_LOAD: state_next = gsdc_pkg::S_TAU;
      gsdc_pkg::S_TAU: begin
        state_next = skip_r ? gsdc_pkg::S_FINISH : gsdc_pkg::S_CORR;
      end
      gsdc_pkg::S_CORR: begin
        if (corr_rsp.done) state_next = gsdc_pkg::S_FINISH;
      end
      gsdc_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = gsdc_pkg::S_IDLE;
      end
      default: state_next = gsdc_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready       = (state == gsdc_pkg::S_IDLE);
    corr_req.start = (state == gsdc_pkg::S_TAU) && !skip_r;
    load_out       = (state == gsdc_pkg::S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_count <= gsdc_pkg::DEC_W'(1);
    end else if (accept) begin
      dec_count <= dec_hit ? gsdc_pkg::DEC_W'(1) : dec_count + 1'b1;
    end
  end

  assign base_next = (win_avg < baseline) ? win_avg : baseline;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline   <= {gsdc_pkg::SAMPLE_W{1'b1}};
      prev_value <= '0;
      prev_time  <= '0;
      started    <= 1'b0;
    end else if (state == gsdc_pkg::S_LOAD) begin
      baseline   <= base_next;
      prev_value <= win_avg;
      prev_time  <= win_time;
      started    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gsdc_pkg::S_LOAD) begin
      avg_r     <= win_avg;
      time_r    <= win_time;
      diff_r    <= win_avg - base_next;
      falling_r <= win_avg < prev_value;
      mag_r     <= (win_avg < prev_value) ? prev_value - win_avg : win_avg - prev_value;
      dt_r      <= win_time - prev_time;
      first_r   <= !started;
      skip_r    <= !started || !(win_time > prev_time);
    end
  end

  always_comb begin
    if (first_r) begin
      tau_next = gsdc_pkg::TAU_W'({rise_offset, 8'd0});
    end else if (falling_r) begin
      tau_next = gsdc_pkg::TAU_W'(decay_slope * diff_r) + gsdc_pkg::TAU_W'({decay_offset, 8'd0});
    end else begin
      tau_next = gsdc_pkg::TAU_W'(rise_slope * diff_r) + gsdc_pkg::TAU_W'({rise_offset, 8'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (state == gsdc_pkg::S_TAU) begin
      tau_r <= tau_next;
    end
  end

  assign corr_req.mag    = mag_r;
  assign corr_req.tau_q8 = tau_next;
  assign corr_req.dt     = dt_r;

  gsdc_corr u_corr (
    .clk (clk),
    .rst (rst),
    .req (corr_req),
    .rsp (corr_rsp)
  );

  always_comb begin
    if (skip_r) begin
      est_wide = $signed({5'd0, avg_r});
    end else if (falling_r) begin
      est_wide = $signed({5'd0, avg_r}) - $signed({2'd0, corr_rsp.quo});
    end else begin
      est_wide = $signed({5'd0, avg_r}) + $signed({2'd0, corr_rsp.quo});
    end
  end

  always_comb begin
    if (!skip_r && corr_rsp.ovf) begin
      est_sat = falling_r ? gsdc_pkg::EST_MIN : gsdc_pkg::EST_MAX;
    end else if (est_wide > gsdc_pkg::ESTX_W'(gsdc_pkg::EST_MAX)) begin
      est_sat = gsdc_pkg::EST_MAX;
    end else if (est_wide < gsdc_pkg::ESTX_W'(gsdc_pkg::EST_MIN)) begin
      est_sat = gsdc_pkg::EST_MIN;
    end else begin
      est_sat = est_wide[gsdc_pkg::EST_W-1:0];
    end
  end

  assign tau_round = (gsdc_pkg::TAU_W+1)'(tau_r) + (gsdc_pkg::TAU_W+1)'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      estimate      <= est_sat;
      time_constant <= gsdc_pkg::TC_W'(tau_round[gsdc_pkg::TAU_W:8]);
      estimate_time <= time_r;
    end
  end

  a_done_in_corr: assert property (@(posedge clk) disable iff (rst)
    corr_rsp.done |-> state == gsdc_pkg::S_CORR)
    else $error("correction unit finished outside the wait state");

  a_load_after_beat: assert property (@(posedge clk) disable iff (rst)
    state == gsdc_pkg::S_LOAD |-> $past(in_valid && in_ready))
    else $error("model load without an input beat");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == gsdc_pkg::S_FINISH && out_valid && !out_ready)
      |=> state == gsdc_pkg::S_FINISH)
    else $error("result left finish while output register was full");

endmodule

// ===== rtl/core/gsdc_cell.sv =====
// One window cell: holds a sample and its timestamp, takes its neighbor's on a shift.
module gsdc_cell (
  input  logic                clk,
  input  gsdc_pkg::win_ctrl_t ctrl,
  input  gsdc_pkg::win_entry_t fresh,
  input  gsdc_pkg::win_entry_t neighbor,
  output gsdc_pkg::win_entry_t entry
);

  gsdc_pkg::win_entry_t held;

  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      held <= fresh;
    end else if (ctrl.shift) begin
      held <= neighbor;
    end
  end

  assign entry = held;

endmodule

// ===== rtl/core/gsdc_window.sv =====
// Sliding window: chain of cells with a running sum, rounded average and centre time.
module gsdc_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [gsdc_pkg::SAMPLE_W-1:0]   sample,
  input  logic [gsdc_pkg::TIME_W-1:0]     sample_time,
  output logic [gsdc_pkg::SAMPLE_W-1:0]   avg,
  output logic [gsdc_pkg::TIME_W-1:0]     centre_time
);

  gsdc_pkg::win_entry_t taps [gsdc_pkg::WINDOW_LEN];
  gsdc_pkg::win_entry_t fresh;
  gsdc_pkg::win_ctrl_t  ctrl;
  logic                 filled;
  logic [gsdc_pkg::SUM_W-1:0] sum;
  logic [gsdc_pkg::SUM_W-1:0] sum_next;
  logic [gsdc_pkg::SUM_W:0]   rounded;
  logic [gsdc_pkg::SUM_W:0]   quot;

  assign fresh.value = sample;
  assign fresh.stamp = sample_time;
  assign ctrl.fill   = push & ~filled;
  assign ctrl.shift  = push & filled;

  for (genvar i = 0; i < gsdc_pkg::WINDOW_LEN; i++) begin : g_cell
    if (i == gsdc_pkg::WINDOW_LEN - 1) begin : g_last
      gsdc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .fresh    (fresh),
        .neighbor (fresh),
        .entry    (taps[i])
      );
    end else begin : g_mid
      gsdc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .fresh    (fresh),
        .neighbor (taps[i+1]),
        .entry    (taps[i])
      );
    end
  end

  // First sample stands for the whole window; afterwards drop the oldest, add the new one.
  always_comb begin
    if (filled) begin
      sum_next = sum - gsdc_pkg::SUM_W'(taps[0].value) + gsdc_pkg::SUM_W'(sample);
    end else begin
      sum_next = gsdc_pkg::SUM_W'(sample) << gsdc_pkg::WIN_LOG2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (push) begin
      filled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum <= sum_next;
    end
  end

  assign rounded = (gsdc_pkg::SUM_W+1)'(sum)
                 + (gsdc_pkg::SUM_W+1)'(gsdc_pkg::WINDOW_LEN / 2);
  assign quot    = rounded >> gsdc_pkg::WIN_LOG2;

  always_comb begin
    if (quot > (gsdc_pkg::SUM_W+1)'({gsdc_pkg::SAMPLE_W{1'b1}})) begin
      avg = {gsdc_pkg::SAMPLE_W{1'b1}};
    end else begin
      avg = quot[gsdc_pkg::SAMPLE_W-1:0];
    end
  end

  assign centre_time = taps[gsdc_pkg::WIN_CENTER].stamp;

endmodule

// ===== rtl/core/gsdc_corr.sv =====
// Correction unit: shift-add multiply then restoring divide, one bit per cycle.
module gsdc_corr (
  input  logic                clk,
  input  logic                rst,
  input  gsdc_pkg::corr_req_t req,
  output gsdc_pkg::corr_rsp_t rsp
);

  gsdc_pkg::corr_state_t state;
  gsdc_pkg::corr_state_t state_next;

  logic [gsdc_pkg::MCAND_W-1:0]  mcand;
  logic [gsdc_pkg::SAMPLE_W-1:0] mplier;
  logic [gsdc_pkg::NUM_W-1:0]    acc;
  logic [gsdc_pkg::DEN_W-1:0]    den;
  logic [gsdc_pkg::REM_W-1:0]    rem;
  logic [gsdc_pkg::REM_W-1:0]    trial;
  logic [gsdc_pkg::QUO_W-1:0]    low;
  logic [gsdc_pkg::QUO_W-1:0]    quo;
  logic                          ovf;
  logic [gsdc_pkg::CNT_W-1:0]    cnt;

  assign trial = {rem[gsdc_pkg::REM_W-2:0], low[gsdc_pkg::QUO_W-1]};

  always_comb begin
    state_next = state;
    case (state)
      gsdc_pkg::C_IDLE: begin
        if (req.start) state_next = gsdc_pkg::C_MUL;
      end
      gsdc_pkg::C_MUL: begin
        if (cnt == gsdc_pkg::CNT_W'(gsdc_pkg::MUL_STEPS - 1)) state_next = gsdc_pkg::C_ADD;
      end
      gsdc_pkg::C_ADD: state_next = gsdc_pkg::C_PRE;
      gsdc_pkg::C_PRE: state_next = gsdc_pkg::C_DIV;
      gsdc_pkg::C_DIV: begin
        if (cnt == gsdc_pkg::CNT_W'(gsdc_pkg::QUO_W - 1)) state_next = gsdc_pkg::C_DONE;
      end
      gsdc_pkg::C_DONE: state_next = gsdc_pkg::C_IDLE;
      default: state_next = gsdc_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == gsdc_pkg::C_DONE);
    rsp.ovf  = ovf;
    rsp.quo  = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsdc_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gsdc_pkg::C_IDLE: begin
        if (req.start) begin
          mcand  <= gsdc_pkg::MCAND_W'(req.tau_q8);
          mplier <= req.mag;
          acc    <= '0;
          den    <= {req.dt, 8'd0};
          cnt    <= '0;
        end
      end
      gsdc_pkg::C_MUL: begin
        if (mplier[0]) acc <= acc + gsdc_pkg::NUM_W'(mcand);
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
      end
      gsdc_pkg::C_ADD: begin
        // add half the divisor for round-half-up
        acc <= acc + gsdc_pkg::NUM_W'(den >> 1);
      end
      gsdc_pkg::C_PRE: begin
        // quotient needs more than QUO_W bits: result saturates anyway
        ovf <= gsdc_pkg::DEN_W'(acc[gsdc_pkg::NUM_W-1:gsdc_pkg::QUO_W]) >= den;
        rem <= gsdc_pkg::REM_W'(acc[gsdc_pkg::NUM_W-1:gsdc_pkg::QUO_W]);
        low <= acc[gsdc_pkg::QUO_W-1:0];
        quo <= '0;
        cnt <= '0;
      end
      gsdc_pkg::C_DIV: begin
        if (trial >= gsdc_pkg::REM_W'(den)) begin
          rem <= trial - gsdc_pkg::REM_W'(den);
          quo <= {quo[gsdc_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[gsdc_pkg::QUO_W-2:0], 1'b0};
        end
        low <= low << 1;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
